// ===== sv/bpd2x_pkg.sv =====
// Package for the 2x binomial pyramid downsampler.
// Register indexes, register reset values and the filter phase type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpd2x_pkg;

	localparam int CFG_BITS     = 11;
	localparam int CFG_IDX_BITS = 2;
	localparam int PLANE_BITS   = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_COUNT  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_COUNT = 2'd2;

	localparam logic [CFG_BITS-1:0]   LINE_LENGTH_RST = 11'd640;
	localparam logic [CFG_BITS-1:0]   LINE_COUNT_RST  = 11'd480;
	localparam logic [PLANE_BITS-1:0] PLANE_COUNT_RST = 3'd3;

	localparam int MIN_LEN = 6;

	// where an output sample sits along one axis
	typedef enum logic [1:0] {
		PH_NONE,
		PH_FIRST,
		PH_MID,
		PH_LAST
	} phase_t;

endpackage

`default_nettype wire

// ===== sv/binomial_pyramid_downsample_2x.sv =====
// 2x binomial pyramid downsampler (5-tap 1-4-6-4-1 reduce), top level.
// Depends on bpd2x_pkg.
//
// Usage:
//   s_* carries source pixels in raster order, plane after plane, one pixel
//   per transfer. m_* carries reduced pixels; m_tlast marks the last pixel of
//   an output line, m_tuser the last pixel of an output plane.
//   cfg_* writes line_length (0), line_count (1) and plane_count (2); any
//   known write restarts the image. Write only while the block is idle.
// Throughput: one pixel per cycle unless stalled. The line store is a single
//   memory of MAX_LINE_LENGTH/2 words, each holding four stored rows; every
//   line-filtered sample does one read and one write of its column word.
// Pipeline: a result passes the tap stage, the memory read stage and the
//   output buffer before it reaches m_tvalid.
// Stall: results go to a two-entry output buffer; s_tready falls only when
//   both entries are full, and the whole pipeline freezes until m_tready.
// Reset: registers return to 640 x 480 x 3, counters and taps clear. The
//   line store is not cleared; rows are always written before being read.
`timescale 1ns / 1ps
`default_nettype none

module binomial_pyramid_downsample_2x #(
	parameter int MAX_LINE_LENGTH = 1024,
	parameter int MAX_LINE_COUNT  = 1024,
	parameter int PIXEL_BITS      = 8,
	localparam int DW = ((PIXEL_BITS + 7) / 8) * 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// slave: [PIXEL_BITS-1:0] pixel_in
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [DW-1:0]                      s_tdata,
	// master: [PIXEL_BITS-1:0] pixel_out
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [DW-1:0]                           m_tdata,
	output logic                                    m_tlast,
	// [0] end_of_plane
	output logic                                    m_tuser,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [bpd2x_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [bpd2x_pkg::CFG_BITS-1:0]     cfg_data
);

	import bpd2x_pkg::*;

	localparam int HALF_LINE = MAX_LINE_LENGTH / 2;
	localparam int XW = $clog2(HALF_LINE);
	localparam int LW = $clog2(MAX_LINE_LENGTH + 1);
	localparam int CW = $clog2(MAX_LINE_LENGTH);
	localparam int HW = $clog2(MAX_LINE_COUNT + 1);
	localparam int RW = $clog2(MAX_LINE_COUNT);
	localparam int PB = PIXEL_BITS;
	localparam int SW = PIXEL_BITS + 4;

	typedef logic [3:0][PB-1:0] word_t;

	logic [CFG_BITS-1:0]   line_length_q, line_count_q;
	logic [PLANE_BITS-1:0] plane_count_q;
	logic [LW-1:0]         w_len;
	logic [HW-1:0]         h_len;
	logic [PLANE_BITS-1:0] n_planes;
	logic [CW-1:0]         col_q;
	logic [RW-1:0]         row_q;
	logic [1:0]            plane_q;
	logic [PB-1:0]         tap_q [4];
	logic                  restart, en, accept;

	logic [PB-1:0] pix;
	logic [LW-1:0] c_ext, c_last, c_mid_hi;
	logic [HW-1:0] r_ext, r_last, r_mid_hi;
	phase_t        hph, vph;
	logic [SW-1:0] hsum;
	logic [XW-1:0] x_in;

	logic          valid_s1, valid_s2;
	logic [PB-1:0] hv_s1, hv_s2;
	logic [XW-1:0] x_s1, x_s2;
	logic [1:0]    lane_s1, lane_s2;
	phase_t        vph_s1, vph_s2;
	logic          eol_s1, eol_s2;
	logic          eop_s1, eop_s2;
	word_t         rdata_s2;
	word_t         wr_word;
	logic [SW-1:0] vsum;
	logic          push, pop;

	word_t mem [HALF_LINE];

	logic          out_v_q, skid_v_q;
	logic [PB-1:0] out_pix_q, skid_pix_q;
	logic          out_eol_q, skid_eol_q, out_eop_q, skid_eop_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_comb begin
		restart = 1'b0;
		if (cfg_valid) begin
			unique case (cfg_index)
				REG_LINE_LENGTH, REG_LINE_COUNT, REG_PLANE_COUNT: restart = 1'b1;
				default: restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LENGTH_RST;
			line_count_q  <= LINE_COUNT_RST;
			plane_count_q <= PLANE_COUNT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LINE_LENGTH: line_length_q <= cfg_data;
				REG_LINE_COUNT:  line_count_q  <= cfg_data;
				REG_PLANE_COUNT: plane_count_q <= cfg_data[PLANE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (line_length_q < CFG_BITS'(MIN_LEN))
			w_len = LW'(MIN_LEN);
		else if (32'(line_length_q) > MAX_LINE_LENGTH)
			w_len = LW'(MAX_LINE_LENGTH);
		else
			w_len = LW'(line_length_q);
		if (line_count_q < CFG_BITS'(MIN_LEN))
			h_len = HW'(MIN_LEN);
		else if (32'(line_count_q) > MAX_LINE_COUNT)
			h_len = HW'(MAX_LINE_COUNT);
		else
			h_len = HW'(line_count_q);
		if (plane_count_q == '0)
			n_planes = PLANE_BITS'(1);
		else if (plane_count_q > PLANE_BITS'(4))
			n_planes = PLANE_BITS'(4);
		else
			n_planes = plane_count_q;
	end

	// handshake
	assign en       = !skid_v_q;
	assign s_tready = en;
	assign accept   = s_tvalid && en;

	// line-direction pass on the incoming pixel
	assign pix      = s_tdata[PB-1:0];
	assign c_ext    = LW'(col_q);
	assign c_last   = (w_len & ~LW'(1)) - LW'(1);
	assign c_mid_hi = (w_len & ~LW'(1)) - LW'(2);
	assign r_ext    = HW'(row_q);
	assign r_last   = (h_len & ~HW'(1)) - HW'(1);
	assign r_mid_hi = (h_len & ~HW'(1)) - HW'(2);

	always_comb begin
		if (c_ext == LW'(2))
			hph = PH_FIRST;
		else if (!col_q[0] && c_ext >= LW'(4) && c_ext <= c_mid_hi)
			hph = PH_MID;
		else if (c_ext == c_last)
			hph = PH_LAST;
		else
			hph = PH_NONE;

		if (r_ext == HW'(2))
			vph = PH_FIRST;
		else if (!row_q[0] && r_ext >= HW'(4) && r_ext <= r_mid_hi)
			vph = PH_MID;
		else if (r_ext == r_last)
			vph = PH_LAST;
		else
			vph = PH_NONE;

		case (hph)
			PH_FIRST: begin
				hsum = SW'(11) * SW'(tap_q[1]) + SW'(4) * SW'(tap_q[0]) + SW'(pix);
				x_in = '0;
			end
			PH_MID: begin
				hsum = SW'(tap_q[3]) + SW'(4) * SW'(tap_q[2]) + SW'(6) * SW'(tap_q[1])
					+ SW'(4) * SW'(tap_q[0]) + SW'(pix);
				x_in = XW'(c_ext[LW-1:1] - (LW-1)'(1));
			end
			PH_LAST: begin
				hsum = SW'(11) * SW'(tap_q[0]) + SW'(4) * SW'(tap_q[1]) + SW'(tap_q[2]);
				x_in = XW'(w_len[LW-1:1] - (LW-1)'(1));
			end
			default: begin
				hsum = '0;
				x_in = '0;
			end
		endcase
	end

	// counters and tap window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
			for (int i = 0; i < 4; i++) tap_q[i] <= '0;
		end else if (restart) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
			for (int i = 0; i < 4; i++) tap_q[i] <= '0;
		end else if (accept) begin
			tap_q[0] <= pix;
			tap_q[1] <= tap_q[0];
			tap_q[2] <= tap_q[1];
			tap_q[3] <= tap_q[2];
			if (c_ext + LW'(1) >= w_len) begin
				col_q <= '0;
				if (r_ext + HW'(1) >= h_len) begin
					row_q <= '0;
					if (PLANE_BITS'(plane_q) + PLANE_BITS'(1) >= n_planes)
						plane_q <= '0;
					else
						plane_q <= plane_q + 2'd1;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept && (hph != PH_NONE);
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hv_s1   <= hsum[SW-1:4];
			x_s1    <= x_in;
			lane_s1 <= row_q[1:0];
			vph_s1  <= vph;
			eol_s1  <= (hph == PH_LAST);
			eop_s1  <= (hph == PH_LAST) && (vph == PH_LAST);
			hv_s2   <= hv_s1;
			x_s2    <= x_s1;
			lane_s2 <= lane_s1;
			vph_s2  <= vph_s1;
			eol_s2  <= eol_s1;
			eop_s2  <= eop_s1;
		end
	end

	// line store: read column word in s1, write it back modified in s2
	always_ff @(posedge clk) begin
		if (en && valid_s2)
			mem[x_s2] <= wr_word;
		if (en && valid_s1)
			rdata_s2 <= mem[x_s1];
	end

	// across-line pass
	always_comb begin
		wr_word          = rdata_s2;
		wr_word[lane_s2] = hv_s2;
		case (vph_s2)
			PH_FIRST:
				vsum = SW'(11) * SW'(rdata_s2[lane_s2 - 2'd2])
					+ SW'(4) * SW'(rdata_s2[lane_s2 - 2'd1]) + SW'(hv_s2);
			PH_MID:
				vsum = SW'(rdata_s2[lane_s2]) + SW'(4) * SW'(rdata_s2[lane_s2 - 2'd3])
					+ SW'(6) * SW'(rdata_s2[lane_s2 - 2'd2])
					+ SW'(4) * SW'(rdata_s2[lane_s2 - 2'd1]) + SW'(hv_s2);
			PH_LAST:
				vsum = SW'(11) * SW'(rdata_s2[lane_s2 - 2'd1])
					+ SW'(4) * SW'(rdata_s2[lane_s2 - 2'd2])
					+ SW'(rdata_s2[lane_s2 - 2'd3]);
			default: vsum = '0;
		endcase
	end

	// two-entry output buffer
	assign push = en && valid_s2 && (vph_s2 != PH_NONE);
	assign pop  = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (push) begin
			if (out_v_q && !pop)
				skid_v_q <= 1'b1;
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q  <= skid_v_q;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_v_q || pop) begin
				out_pix_q <= vsum[SW-1:4];
				out_eol_q <= eol_s2;
				out_eop_q <= eop_s2;
			end else begin
				skid_pix_q <= vsum[SW-1:4];
				skid_eol_q <= eol_s2;
				skid_eop_q <= eop_s2;
			end
		end else if (pop && skid_v_q) begin
			out_pix_q <= skid_pix_q;
			out_eol_q <= skid_eol_q;
			out_eop_q <= skid_eop_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = DW'(out_pix_q);
	assign m_tlast  = out_eol_q;
	assign m_tuser  = out_eop_q;

	// checks
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s1 && valid_s2 |-> x_s1 != x_s2)
		else $error("line store read and write hit the same column");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		c_ext < w_len)
		else $error("column counter beyond line length");

	a_plane_end_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("plane end without row end");

	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !en |=> valid_s2 && $stable(x_s2) && $stable(hv_s2))
		else $error("stalled stage two changed");

endmodule

`default_nettype wire
